/* rtl/lrse_pkg.sv */
// Shared types, constants and the log2 step function of the log-ratio scan effect.
package lrse_pkg;

  localparam int unsigned FramePixelsDef = 262144;
  localparam int unsigned LogFracBitsDef = 12;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic [1:0] CFG_LOW_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LOG_GAIN  = 2'd1;
  localparam logic [1:0] CFG_FADE_IN   = 2'd2;
  localparam logic [1:0] CFG_FADE_OUT  = 2'd3;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ARMED   = 2'd1;
  localparam logic [1:0] MODE_RUNNING = 2'd2;

  localparam logic [1:0] ACT_PASS    = 2'd0;
  localparam logic [1:0] ACT_RISE    = 2'd1;
  localparam logic [1:0] ACT_FALL    = 2'd2;
  localparam logic [1:0] ACT_CAPTURE = 2'd3;

  localparam logic [16:0] FadeOne = 17'd65536;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] pixel_in;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_out;
    logic        last_out;
  } out_item_t;

  // One squaring round of the mantissa log: returns {bit, next mantissa}.
  function automatic logic [16:0] log_round(input logic [15:0] y);
    logic [31:0] sq;
    logic [16:0] t;
    begin
      sq = 32'(y) * 32'(y);
      t = sq[31:15];
      if (t[16]) log_round = {1'b1, t[16:1]};
      else log_round = {1'b0, t[15:0]};
    end
  endfunction

endpackage

/* rtl/log_ratio_scan_effect.sv */
// Log-ratio scan effect: reference frame memory, pipelined log2, map and fade blend.
//
//  Channel | Direction | Handshake                 | Payload
//  in      | input     | in_valid_i / in_stall_o   | lrse_pkg::in_item_t
//  out     | output    | out_valid_o / out_stall_i | lrse_pkg::out_item_t
//  cfg     | input     | cfg_we_i, cfg_idx_i       | cfg_data_i (32 bits)
//
// One item per cycle while the output does not stall; a pixel passes stage 0,
// normalize, one squaring round per log2 stage, map stages A-C, output register.
// Reset clears control state; the reference memory is not cleared.
// A stall on the output freezes the whole pipeline; the input stalls only then.
module log_ratio_scan_effect #(
  parameter int unsigned FRAME_PIXELS  = lrse_pkg::FramePixelsDef,
  parameter int unsigned LOG_FRAC_BITS = lrse_pkg::LogFracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lrse_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lrse_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);
  import lrse_pkg::*;

  localparam int unsigned AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
  localparam int unsigned CW = $clog2(FRAME_PIXELS + 1);
  localparam int unsigned NS = LOG_FRAC_BITS;
  localparam int unsigned LW = LOG_FRAC_BITS + 5;

  logic signed [17:0] low_limit_q;
  logic [31:0] log_gain_q;
  logic [16:0] fade_in_q, fade_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q <= -18'sd4096;
      log_gain_q  <= 32'd524280;
      fade_in_q   <= 17'd13107;
      fade_out_q  <= 17'd6554;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_LIMIT: low_limit_q <= cfg_data_i[17:0];
        CFG_LOG_GAIN:  log_gain_q  <= cfg_data_i;
        CFG_FADE_IN:   fade_in_q   <= cfg_data_i[16:0];
        CFG_FADE_OUT:  fade_out_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  logic acc;
  assign acc = in_valid_i && adv;

  // Control state: updated at acceptance. The fade used by a pixel is the value
  // current when it enters; later frames' updates cannot reach it before output
  // since fade only changes at a frame's last pixel or by commands after it.
  logic [1:0]    mode_q, act_q;
  logic [16:0]   fade_q;
  logic [CW-1:0] cnt_q;

  logic [1:0]  act_now;
  logic        is_pix, last_now;
  logic [16:0] fade_sum;
  always_comb begin
    is_pix = in_data_i.opcode == OP_PIXEL;
    act_now = act_q;
    if (cnt_q == '0) begin
      if (mode_q == MODE_ARMED) act_now = ACT_CAPTURE;
      else if (mode_q == MODE_RUNNING) act_now = ACT_RISE;
      else if (fade_q != '0) act_now = ACT_FALL;
      else act_now = ACT_PASS;
    end
    last_now = in_data_i.frame_end || (cnt_q == CW'(FRAME_PIXELS - 1));
    fade_sum = ((18'(fade_q) + 18'(fade_in_q)) > 18'(FadeOne)) ? FadeOne
             : 17'(fade_q + fade_in_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      act_q  <= ACT_PASS;
      fade_q <= '0;
      cnt_q  <= '0;
    end else if (acc) begin
      case (in_data_i.opcode)
        OP_START: begin
          if (mode_q == MODE_IDLE) fade_q <= '0;
          mode_q <= MODE_ARMED;
        end
        OP_STOP: begin
          fade_q <= (mode_q == MODE_RUNNING) ? FadeOne : 17'd0;
          mode_q <= MODE_IDLE;
        end
        OP_PIXEL: begin
          act_q <= act_now;
          if (cnt_q == '0 && mode_q == MODE_ARMED) mode_q <= MODE_RUNNING;
          if (last_now) begin
            cnt_q <= '0;
            if (act_now == ACT_RISE || act_now == ACT_CAPTURE) fade_q <= fade_sum;
            else if (act_now == ACT_FALL)
              fade_q <= (fade_q > fade_out_q) ? 17'(fade_q - fade_out_q) : 17'd0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Reference memory: written in capture frames; the read is registered.
  logic [15:0] ref_mem [FRAME_PIXELS];
  logic [15:0] ref_rd_q;
  logic [AW-1:0] addr;
  assign addr = cnt_q[AW-1:0];
  always_ff @(posedge clk_i) begin
    if (acc && is_pix) begin
      if (act_now == ACT_CAPTURE) ref_mem[addr] <= in_data_i.pixel_in;
      ref_rd_q <= ref_mem[addr];
    end
  end

  // Stage 0: item registered alongside the memory read.
  logic        v0_q, cap0_q, pass0_q, last0_q;
  logic [15:0] raw0_q;
  logic [16:0] fade0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= acc && is_pix;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw0_q  <= in_data_i.pixel_in;
      cap0_q  <= act_now == ACT_CAPTURE;
      pass0_q <= act_now == ACT_PASS;
      last0_q <= last_now;
      fade0_q <= fade_q;
    end
  end

  // Stage 1: normalize both values (exponent and Q1.15 mantissa).
  function automatic logic [19:0] norm(input logic [15:0] x);
    logic [15:0] xx;
    logic [3:0]  e;
    begin
      xx = (x == 16'd0) ? 16'd1 : x;
      e = 4'd0;
      for (int i = 0; i < 16; i++) if (xx[i]) e = 4'(i);
      norm = {e, 16'(xx << (4'd15 - e))};
    end
  endfunction

  logic [19:0] ref_src;
  assign ref_src = norm(cap0_q ? raw0_q : ref_rd_q);

  logic          v_q   [NS+1];
  logic          pass_q[NS+1];
  logic          last_q[NS+1];
  logic [15:0]   raw_q [NS+1];
  logic [16:0]   fd_q  [NS+1];
  logic [3:0]    ep_q  [NS+1], er_q [NS+1];
  logic [15:0]   yp_q  [NS+1], yr_q [NS+1];
  logic [NS-1:0] fp_q  [NS+1], fr_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) v_q[s] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= v0_q;
      for (int s = 1; s <= NS; s++) v_q[s] <= v_q[s-1];
    end
  end

  logic [19:0] pix_src;
  assign pix_src = norm(raw0_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pass_q[0] <= pass0_q;
      last_q[0] <= last0_q;
      raw_q[0]  <= raw0_q;
      fd_q[0]   <= fade0_q;
      ep_q[0]   <= pix_src[19:16];
      yp_q[0]   <= pix_src[15:0];
      er_q[0]   <= ref_src[19:16];
      yr_q[0]   <= ref_src[15:0];
      fp_q[0]   <= '0;
      fr_q[0]   <= '0;
      for (int s = 1; s <= NS; s++) begin
        logic [16:0] rp, rr;
        rp = log_round(yp_q[s-1]);
        rr = log_round(yr_q[s-1]);
        pass_q[s] <= pass_q[s-1];
        last_q[s] <= last_q[s-1];
        raw_q[s]  <= raw_q[s-1];
        fd_q[s]   <= fd_q[s-1];
        ep_q[s]   <= ep_q[s-1];
        er_q[s]   <= er_q[s-1];
        yp_q[s]   <= rp[15:0];
        yr_q[s]   <= rr[15:0];
        fp_q[s]   <= {fp_q[s-1][NS-2:0], rp[16]};
        fr_q[s]   <= {fr_q[s-1][NS-2:0], rr[16]};
      end
    end
  end

  // Map stage A: difference minus low limit.
  logic signed [LW+2:0] d_c;
  assign d_c = $signed({4'b0, ep_q[NS], fp_q[NS]}) - $signed({4'b0, er_q[NS], fr_q[NS]})
             - (LW+3)'(low_limit_q);

  logic        va_q, pa_q, la_q, neg_a_q;
  logic [15:0] ra_q;
  logic [16:0] fa_q;
  logic [LW+1:0] da_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else if (adv) va_q <= v_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pa_q <= pass_q[NS]; la_q <= last_q[NS]; ra_q <= raw_q[NS]; fa_q <= fd_q[NS];
      neg_a_q <= d_c[LW+2];
      da_q <= d_c[LW+1:0];
    end
  end

  // Map stage B: gain multiply (the difference is held in LW+2 bits, 19 by default).
  logic        vb_q, pb_q, lb_q, nb_q;
  logic [15:0] rb_q;
  logic [16:0] fb_q;
  logic [LW+33:0] pr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else if (adv) vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pb_q <= pa_q; lb_q <= la_q; rb_q <= ra_q; fb_q <= fa_q; nb_q <= neg_a_q;
      pr_q <= (LW+34)'(da_q) * (LW+34)'(log_gain_q);
    end
  end

  // Map stage C: clamp.
  logic [15:0] v_c;
  assign v_c = nb_q ? 16'd0 : ((pr_q[LW+33:16] > (LW+18)'(16'hFFFF)) ? 16'hFFFF
             : pr_q[31:16]);

  logic        vc_q, pc_q, lc_q;
  logic [15:0] rc_q, mc_q;
  logic [16:0] fc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else if (adv) vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pc_q <= pb_q; lc_q <= lb_q; rc_q <= rb_q; fc_q <= fb_q; mc_q <= v_c;
    end
  end

  // Blend stage: two 16x17 products, summed into the output register; pass and full fade bypass it.
  logic [16:0] inv_f;
  logic [33:0] blend;
  logic [15:0] res;
  always_comb begin
    inv_f = 17'(FadeOne - fc_q);
    blend = 34'(rc_q) * 34'(inv_f) + 34'(mc_q) * 34'(fc_q);
    if (pc_q) res = rc_q;
    else if (fc_q[16]) res = mc_q;
    else res = blend[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (adv) out_valid_o <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.pixel_out <= res;
      out_data_o.last_out  <= lc_q;
    end
  end

endmodule
